>>> sv/bc1_bc2_bc3_block_decoder_top_macros.svh
// Assertion macros shared by the block decoder RTL.
`ifndef BC1_BC2_BC3_BLOCK_DECODER_TOP_MACROS_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_TOP_MACROS_SVH

// Checks a consequent in the same cycle as its antecedent.
`define BCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define BCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bcd_pkg.sv
// Shared types, codes and constant-divisor arithmetic for the block decoder.
package bcd_pkg;

  // Block format codes held in the format register.
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // Register index of the format register (paddr bit 2 selects the word).
  localparam logic CFG_IDX_FORMAT = 1'b0;
  localparam int   ADDR_W         = 3;

  // Reciprocals for exact division by small constants over bounded ranges.
  localparam logic [13:0] RECIP31 = 14'd8457;   // shift 18, n <= 7905
  localparam logic [14:0] RECIP63 = 15'd16645;  // shift 20, n <= 16065
  localparam logic [10:0] RECIP3  = 11'd1366;   // shift 12, n <= 766
  localparam logic [11:0] RECIP7  = 12'd2341;   // shift 14, n <= 1788
  localparam logic [10:0] RECIP5  = 11'd1639;   // shift 13, n <= 1277

  // Input transaction: one compressed 4x4 block.
  typedef struct packed {
    logic [63:0] color_word;
    logic [63:0] alpha_word;
  } bcd_in_t;

  // Output transaction: one texel row of four BGRA8 pixels.
  typedef struct packed {
    logic [1:0]  row_index;
    logic [31:0] pixel_col0;
    logic [31:0] pixel_col1;
    logic [31:0] pixel_col2;
    logic [31:0] pixel_col3;
    logic        last_row;
  } bcd_out_t;

  // Decoded palettes and raw indices of one block, as held for row output.
  typedef struct packed {
    logic [1:0]       fmt;
    logic             three;
    logic [3:0][23:0] pal;
    logic [7:0][7:0]  apal;
    logic [31:0]      cidx;
    logic [63:0]      aw;
  } bcd_pal_t;

  // floor(n / 31) for n <= 7905.
  function automatic logic [7:0] div31(input logic [12:0] n);
    logic [26:0] p;
    p = 27'(n) * 27'(RECIP31);
    return p[25:18];
  endfunction

  // floor(n / 63) for n <= 16065.
  function automatic logic [7:0] div63(input logic [13:0] n);
    logic [29:0] p;
    p = 30'(n) * 30'(RECIP63);
    return p[27:20];
  endfunction

  // floor(n / 3) for n <= 766.
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [21:0] p;
    p = 22'(n) * 22'(RECIP3);
    return p[19:12];
  endfunction

  // floor(n / 7) for n <= 1788.
  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [24:0] p;
    p = 25'(n) * 25'(RECIP7);
    return p[21:14];
  endfunction

  // floor(n / 5) for n <= 1277.
  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [23:0] p;
    p = 24'(n) * 24'(RECIP5);
    return p[20:13];
  endfunction

  // Widen a 5-bit channel with x*255/31.
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [12:0] n;
    n = 13'({x, 8'b0}) - 13'(x);
    return div31(n);
  endfunction

  // Widen a 6-bit channel with x*255/63.
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [13:0] n;
    n = 14'({x, 8'b0}) - 14'(x);
    return div63(n);
  endfunction

endpackage

>>> sv/bc1_bc2_bc3_block_decoder_top.sv
// Top level of the BC1/BC2/BC3 texel block decoder.
//
// Input channel (in_valid/in_ready/in_data): one transaction is one
// compressed 4x4 block, a colour word plus an alpha word used by BC2/BC3.
// Output channel (out_valid/out_ready/out_data): four transactions per
// block, texel rows 0 to 3 in order, each with four BGRA8 pixels; the
// fourth carries last_row.
// Configuration: an APB-style port with one register, the block format
// (0 BC1, 1 BC2, 2 BC3, 3 treated as BC3) at byte address 0. The user
// must write it only while the decoder is idle; the decoder does not enforce it.
// Row 0 of a block passes the input, endpoint, palette and output registers
// before it is offered; rows 1 to 3 follow one per cycle when not stalled.
// Throughput: one block per four rows, the output channel carrying one row
// per cycle when not stalled. Three pipeline stages (input, endpoint
// expansion, palette) keep blocks flowing while earlier rows drain.
// Reset clears all valid flags and the format register (BC1).
// When the receiver stalls, the held row stays on out_data, the pipeline
// fills and in_ready falls; nothing is lost or repeated.
module bc1_bc2_bc3_block_decoder_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bcd_pkg::bcd_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bcd_pkg::bcd_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bcd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Expanded endpoints and weighted alpha sums of one block.
  typedef struct packed {
    logic [1:0]       fmt;
    logic             three;
    logic [23:0]      c0;
    logic [23:0]      c1;
    logic             agt;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [5:0][10:0] asum;
    logic [31:0]      cidx;
    logic [63:0]      aw;
  } mid_t;

  logic [1:0]        fmt_r;
  logic              a_valid_r;
  bcd_pkg::bcd_in_t  a_data_r;
  logic [1:0]        a_fmt_r;
  logic              m_valid_r;
  mid_t              m_r;
  mid_t              m_nxt;
  logic              b_valid_r;
  bcd_pkg::bcd_pal_t b_r;
  bcd_pkg::bcd_pal_t b_nxt;
  logic [1:0]        row_r;
  logic              out_valid_r;
  bcd_pkg::bcd_out_t out_data_r;
  bcd_pkg::bcd_out_t row_out;
  logic              out_load;
  logic              b_take;
  logic              m_take;
  logic              cfg_wr;

  // Configuration register write and read-back.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == bcd_pkg::CFG_IDX_FORMAT);
  assign prdata = (paddr[2] == bcd_pkg::CFG_IDX_FORMAT) ? {30'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= bcd_pkg::FMT_BC1;
    end else if (cfg_wr) begin
      fmt_r <= pwdata[1:0];
    end
  end

  // Pipeline flow control, driven back from the output register.
  assign out_load = b_valid_r && (!out_valid_r || out_ready);
  assign b_take   = !b_valid_r || (out_load && (row_r == 2'd3));
  assign m_take   = !m_valid_r || b_take;
  assign in_ready = !a_valid_r || m_take;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
    if (in_ready) begin
      a_data_r <= in_data;
      a_fmt_r  <= fmt_r;
    end
  end

  // Endpoint expansion, colour mode and weighted alpha sums.
  always_comb begin
    logic [15:0] e0;
    logic [15:0] e1;
    e0 = a_data_r.color_word[15:0];
    e1 = a_data_r.color_word[31:16];
    m_nxt.fmt   = a_fmt_r;
    m_nxt.three = (a_fmt_r == bcd_pkg::FMT_BC1) && (e0 <= e1);
    m_nxt.c0    = {bcd_pkg::expand5(e0[15:11]), bcd_pkg::expand6(e0[10:5]),
                   bcd_pkg::expand5(e0[4:0])};
    m_nxt.c1    = {bcd_pkg::expand5(e1[15:11]), bcd_pkg::expand6(e1[10:5]),
                   bcd_pkg::expand5(e1[4:0])};
    m_nxt.a0    = a_data_r.alpha_word[7:0];
    m_nxt.a1    = a_data_r.alpha_word[15:8];
    m_nxt.agt   = m_nxt.a0 > m_nxt.a1;
    for (int k = 1; k <= 6; k++) begin
      if (m_nxt.agt) begin
        m_nxt.asum[k-1] = 11'(7 - k) * 11'(m_nxt.a0) + 11'(k) * 11'(m_nxt.a1) + 11'd3;
      end else if (k <= 4) begin
        m_nxt.asum[k-1] = 11'(5 - k) * 11'(m_nxt.a0) + 11'(k) * 11'(m_nxt.a1) + 11'd2;
      end else begin
        m_nxt.asum[k-1] = 11'd0;
      end
    end
    m_nxt.cidx = a_data_r.color_word[63:32];
    m_nxt.aw   = a_data_r.alpha_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (m_take) begin
      m_valid_r <= a_valid_r;
    end
    if (m_take) begin
      m_r <= m_nxt;
    end
  end

  // Colour and alpha palettes.
  always_comb begin
    logic [7:0] ca;
    logic [7:0] cb;
    logic [8:0] half;
    b_nxt.fmt    = m_r.fmt;
    b_nxt.three  = m_r.three;
    b_nxt.pal[0] = m_r.c0;
    b_nxt.pal[1] = m_r.c1;
    for (int ch = 0; ch < 3; ch++) begin
      ca   = m_r.c0[8*ch +: 8];
      cb   = m_r.c1[8*ch +: 8];
      half = 9'(ca) + 9'(cb);
      if (m_r.three) begin
        b_nxt.pal[2][8*ch +: 8] = half[8:1];
        b_nxt.pal[3][8*ch +: 8] = 8'd0;
      end else begin
        b_nxt.pal[2][8*ch +: 8] = bcd_pkg::div3({1'b0, ca, 1'b0} + 10'(cb) + 10'd1);
        b_nxt.pal[3][8*ch +: 8] = bcd_pkg::div3(10'(ca) + {1'b0, cb, 1'b0} + 10'd1);
      end
    end
    b_nxt.apal[0] = m_r.a0;
    b_nxt.apal[1] = m_r.a1;
    for (int k = 1; k <= 6; k++) begin
      if (m_r.agt) begin
        b_nxt.apal[k+1] = bcd_pkg::div7(m_r.asum[k-1]);
      end else if (k <= 4) begin
        b_nxt.apal[k+1] = bcd_pkg::div5(m_r.asum[k-1]);
      end else if (k == 5) begin
        b_nxt.apal[k+1] = 8'd0;
      end else begin
        b_nxt.apal[k+1] = 8'd255;
      end
    end
    b_nxt.cidx = m_r.cidx;
    b_nxt.aw   = m_r.aw;
  end

  // Palette register and row counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      row_r     <= 2'd0;
    end else begin
      if (b_take) begin
        b_valid_r <= m_valid_r;
      end
      if (out_load) begin
        row_r <= row_r + 2'd1;
      end
    end
    if (b_take) begin
      b_r <= b_nxt;
    end
  end

  bcd_row_sel u_row_sel (
    .blk     (b_r),
    .row     (row_r),
    .row_out (row_out)
  );

  // Output register: holds a row until the receiver takes the transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= row_out;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Assertions.
  `include "bc1_bc2_bc3_block_decoder_top_macros.svh"

  `BCD_ASSERT_NOW(a_last_flag, out_valid, out_data.last_row == (out_data.row_index == 2'd3), "last_row does not match row_index")
  `BCD_ASSERT_NEXT(a_row_seq, out_valid && out_ready && !out_data.last_row, out_valid && (out_data.row_index == $past(out_data.row_index) + 2'd1), "row sequence broken")
  `BCD_ASSERT_NEXT(a_blk_hold, b_valid_r && !out_load, b_valid_r && $stable(row_r), "palette stage lost a block")

endmodule

>>> sv/bcd_row_sel.sv
// Row pixel assembly: picks colour and alpha for the four texels of one row.
module bcd_row_sel (
  input  bcd_pkg::bcd_pal_t blk,
  input  logic [1:0]        row,
  output bcd_pkg::bcd_out_t row_out
);

  logic [3:0][31:0] px;

  // Each column is independent: index lookup, then palette selection.
  always_comb begin
    logic [3:0] t;
    logic [1:0] ci;
    logic [3:0] a4;
    logic [5:0] aoff;
    logic [2:0] ai;
    for (int c = 0; c < 4; c++) begin
      t    = {row, 2'(c)};
      ci   = blk.cidx[{t, 1'b0} +: 2];
      a4   = blk.aw[{t, 2'b00} +: 4];
      aoff = 6'd16 + {2'b00, t} + {1'b0, t, 1'b0};
      ai   = blk.aw[aoff +: 3];
      unique case (blk.fmt)
        bcd_pkg::FMT_BC1: begin
          // Index 3 in three-colour mode is transparent black.
          if (blk.three && (ci == 2'd3)) begin
            px[c] = 32'd0;
          end else begin
            px[c] = {8'hff, blk.pal[ci]};
          end
        end
        bcd_pkg::FMT_BC2: begin
          // a*255/15 equals a*17, which is the nibble repeated.
          px[c] = {a4, a4, blk.pal[ci]};
        end
        default: begin
          px[c] = {blk.apal[ai], blk.pal[ci]};
        end
      endcase
    end
  end

  assign row_out.row_index  = row;
  assign row_out.pixel_col0 = px[0];
  assign row_out.pixel_col1 = px[1];
  assign row_out.pixel_col2 = px[2];
  assign row_out.pixel_col3 = px[3];
  assign row_out.last_row   = (row == 2'd3);

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the BC1/BC2/BC3 texel block decoder.
module tb_top;

  // Format code 3 is not named in the package; the decoder treats it as BC3.
  localparam logic [1:0] FMT_BC3_ALT    = 2'd3;
  // Register index 1 does not exist, so writes to it must be ignored.
  localparam logic       CFG_IDX_UNUSED = 1'b1;
  localparam int         AW             = bcd_pkg::ADDR_W;
  localparam int         IDLE_LIMIT     = 2000;
  localparam int         BLOCKS_PER_PHASE = 40;
  localparam int         NUM_DIRECTED   = 20;

  // One row of the directed table: format, block words and, where it is
  // obvious, the single pixel value that every texel of the block decodes to.
  typedef struct packed {
    logic [1:0]  fmt;
    logic [63:0] color_word;
    logic [63:0] alpha_word;
    logic        uniform;
    logic [31:0] pixel;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  bcd_pkg::bcd_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  bcd_pkg::bcd_out_t out_data;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AW-1:0]     paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  bcd_pkg::bcd_out_t expected_rows [$];
  logic [1:0]        format_model;
  int                n_errors;
  int                burst_left;
  int unsigned       idle_cycles;
  int unsigned       ready_step;
  logic [7:0]        ready_pattern = 8'hff;
  logic [1:0]        phase_fmt [5];

  // Directed blocks: extremes of both words, every palette mode and format.
  stim_row_t directed_blocks [NUM_DIRECTED] = '{
    '{bcd_pkg::FMT_BC1, 64'h0, 64'h0, 1'b1, 32'hff000000},
    '{bcd_pkg::FMT_BC1, 64'hffff_ffff_ffff_ffff, 64'h0, 1'b1, 32'h00000000},
    '{bcd_pkg::FMT_BC1, 64'h0000_0000_0000_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 32'hffffffff},
    '{bcd_pkg::FMT_BC1, 64'h5555_5555_0000_ffff, 64'h0, 1'b1, 32'hff000000},
    '{bcd_pkg::FMT_BC1, 64'he4e4_e4e4_0000_ffff, 64'h0, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC1, 64'he4e4_e4e4_ffff_0000, 64'h0, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC1, 64'h1b1b_1b1b_7bef_7bef, 64'h0, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC1, 64'haaaa_aaaa_f800_07e0, 64'hffff_ffff_ffff_ffff, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC2, 64'h0, 64'h0, 1'b1, 32'h00000000},
    '{bcd_pkg::FMT_BC2, 64'h0000_0000_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 32'hffffffff},
    '{bcd_pkg::FMT_BC2, 64'hffff_ffff_f81f_001f, 64'hfedc_ba98_7654_3210, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC2, 64'he4e4_e4e4_1234_abcd, 64'h0123_4567_89ab_cdef, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC3, 64'h0, 64'hffff_ffff_ffff_ffff, 1'b1, 32'hff000000},
    '{bcd_pkg::FMT_BC3, 64'he4e4_e4e4_0000_ffff, 64'hfac6_88fa_c688_00ff, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC3, 64'he4e4_e4e4_ffff_0000, 64'hfac6_88fa_c688_ff00, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC3, 64'h3690_36c9_5a5a_a5a5, 64'hfac6_88fa_c688_8080, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC3, 64'h0, 64'h0, 1'b1, 32'h00000000},
    '{FMT_BC3_ALT, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 32'hffffffff},
    '{FMT_BC3_ALT, 64'h3690_36c9_5a5a_a5a5, 64'hfac6_88fa_c688_10f0, 1'b0, 32'h0},
    '{bcd_pkg::FMT_BC1, 64'hffff_ffff_0000_0000, 64'h0, 1'b1, 32'h00000000}
  };

  bc1_bc2_bc3_block_decoder_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock with a period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Widens a 565 endpoint to 8 bits per channel, packed as R, G, B.
  function automatic logic [23:0] widen_565(input logic [15:0] c);
    int unsigned r, g, b;
    b = int'(c[4:0]) * 255 / 31;
    g = int'(c[10:5]) * 255 / 63;
    r = int'(c[15:11]) * 255 / 31;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  // Weighted per-channel mix of two RGB colours with rounding term and divisor.
  function automatic logic [23:0] mix_rgb(input logic [23:0] a, input int unsigned wa,
                                          input logic [23:0] b, input int unsigned wb,
                                          input int unsigned rnd, input int unsigned div);
    logic [23:0] res;
    int unsigned v;
    for (int ch = 0; ch < 3; ch++) begin
      v = (int'(a[8*ch +: 8]) * wa + int'(b[8*ch +: 8]) * wb + rnd) / div;
      res[8*ch +: 8] = v[7:0];
    end
    return res;
  endfunction

  // Decodes one block under the given format and queues its four texel rows.
  function automatic void decode_block_rows(input logic [1:0] fmt,
                                            input bcd_pkg::bcd_in_t blk);
    logic [15:0] e0, e1;
    logic [23:0] pal [4];
    int unsigned apal [8];
    logic        three;
    int unsigned ci, ai, a;
    int          t;
    logic [31:0] px [4];
    bcd_pkg::bcd_out_t row;
    e0 = blk.color_word[15:0];
    e1 = blk.color_word[31:16];
    three = (fmt == bcd_pkg::FMT_BC1) && (e0 <= e1);
    pal[0] = widen_565(e0);
    pal[1] = widen_565(e1);
    if (three) begin
      pal[2] = mix_rgb(pal[0], 1, pal[1], 1, 0, 2);
      pal[3] = 24'h0;
    end else begin
      pal[2] = mix_rgb(pal[0], 2, pal[1], 1, 1, 3);
      pal[3] = mix_rgb(pal[0], 1, pal[1], 2, 1, 3);
    end
    // BC3 alpha palette: sevenths when a0 > a1, else fifths plus 0 and 255.
    apal[0] = blk.alpha_word[7:0];
    apal[1] = blk.alpha_word[15:8];
    if (apal[0] > apal[1]) begin
      for (int k = 1; k <= 6; k++)
        apal[k+1] = ((7 - k) * apal[0] + k * apal[1] + 3) / 7;
    end else begin
      for (int k = 1; k <= 4; k++)
        apal[k+1] = ((5 - k) * apal[0] + k * apal[1] + 2) / 5;
      apal[6] = 0;
      apal[7] = 255;
    end
    for (int r = 0; r < 4; r++) begin
      for (int col = 0; col < 4; col++) begin
        t = 4 * r + col;
        ci = blk.color_word[32 + 2*t +: 2];
        if (fmt == bcd_pkg::FMT_BC1) begin
          // Index 3 in three-colour mode is transparent black.
          px[col] = (three && ci == 3) ? 32'h0 : {8'hff, pal[ci]};
        end else if (fmt == bcd_pkg::FMT_BC2) begin
          a = int'(blk.alpha_word[4*t +: 4]) * 255 / 15;
          px[col] = {a[7:0], pal[ci]};
        end else begin
          ai = blk.alpha_word[16 + 3*t +: 3];
          px[col] = {apal[ai][7:0], pal[ci]};
        end
      end
      row.row_index  = r[1:0];
      row.pixel_col0 = px[0];
      row.pixel_col1 = px[1];
      row.pixel_col2 = px[2];
      row.pixel_col3 = px[3];
      row.last_row   = (r == 3);
      expected_rows.push_back(row);
    end
  endfunction

  // Queues four rows in which every pixel has the same value.
  function automatic void queue_uniform_rows(input logic [31:0] pix);
    bcd_pkg::bcd_out_t row;
    for (int r = 0; r < 4; r++) begin
      row = '{row_index: r[1:0], pixel_col0: pix, pixel_col1: pix, pixel_col2: pix,
              pixel_col3: pix, last_row: (r == 3)};
      expected_rows.push_back(row);
    end
  endfunction

  // Random block with biased endpoint and alpha orderings, equal values included.
  function automatic bcd_pkg::bcd_in_t random_block(input logic [1:0] fmt);
    logic [15:0] e0, e1;
    logic [7:0]  a0, a1;
    bcd_pkg::bcd_in_t blk;
    e0 = 16'($urandom);
    e1 = 16'($urandom);
    case ($urandom_range(0, 7))
      0: e1 = e0;
      1: e0 = 16'h0000;
      2: e0 = 16'hffff;
      3: e1 = 16'hffff;
      4: e1 = 16'h0000;
      default: ;
    endcase
    a0 = 8'($urandom);
    a1 = 8'($urandom);
    case ($urandom_range(0, 5))
      0: a1 = a0;
      1: a0 = 8'h00;
      2: a0 = 8'hff;
      3: a1 = 8'hff;
      default: ;
    endcase
    blk.color_word = {32'($urandom), e1, e0};
    if (fmt == bcd_pkg::FMT_BC2)
      blk.alpha_word = {32'($urandom), 32'($urandom)};
    else
      blk.alpha_word = {32'($urandom), 16'($urandom), a1, a0};
    return blk;
  endfunction

  // One register write: setup cycle, access cycle, then the bus goes idle.
  task automatic write_register(input logic idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == bcd_pkg::CFG_IDX_FORMAT)
      format_model = data[1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops sending and waits until every queued row has been received.
  task automatic drain_rows();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  // Changes format while idle, with a stray write to the unused index first.
  task automatic set_format(input logic [1:0] fmt);
    logic [31:0] junk;
    junk = $urandom;
    drain_rows();
    write_register(CFG_IDX_UNUSED, junk);
    write_register(bcd_pkg::CFG_IDX_FORMAT, ($urandom & ~32'h3) | 32'(fmt));
  endtask

  // Offers one block in bursts with random gaps, and predicts it on acceptance.
  task automatic send_block(input bcd_pkg::bcd_in_t blk, input logic uniform,
                            input logic [31:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= blk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (uniform)
      queue_uniform_rows(pix);
    else
      decode_block_rows(format_model, blk);
    burst_left--;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      n_errors++;
    end
  endtask

  // Receiver stall patterns, redrawn by ready_step; a quarter of them never stall.
  always @(negedge clk) begin
    ready_step++;
    if (ready_step % 64 == 0)
      ready_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
    out_ready <= ready_pattern[ready_step % 8];
  end

  // Compare each received row with the oldest expectation.
  always @(posedge clk) begin
    bcd_pkg::bcd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row, expected none, got %h", $time, out_data);
        n_errors++;
      end else begin
        want = expected_rows.pop_front();
        check_field("row_index",  32'(want.row_index), 32'(out_data.row_index));
        check_field("pixel_col0", want.pixel_col0, out_data.pixel_col0);
        check_field("pixel_col1", want.pixel_col1, out_data.pixel_col1);
        check_field("pixel_col2", want.pixel_col2, out_data.pixel_col2);
        check_field("pixel_col3", want.pixel_col3, out_data.pixel_col3);
        check_field("last_row",   32'(want.last_row), 32'(out_data.last_row));
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, then drain and report.
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    format_model  = bcd_pkg::FMT_BC1;
    n_errors      = 0;
    burst_left    = 0;
    idle_cycles   = 0;
    ready_step    = 0;
    phase_fmt     = '{bcd_pkg::FMT_BC2, bcd_pkg::FMT_BC1, bcd_pkg::FMT_BC3, FMT_BC3_ALT,
                      bcd_pkg::FMT_BC1};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_blocks[i].fmt != format_model)
        set_format(directed_blocks[i].fmt);
      send_block({directed_blocks[i].color_word, directed_blocks[i].alpha_word},
                 directed_blocks[i].uniform, directed_blocks[i].pixel);
    end

    for (int p = 0; p < 5; p++) begin
      set_format(phase_fmt[p]);
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        // Once mid-phase, hold off until the decoder has emptied.
        if (p == 2 && n == BLOCKS_PER_PHASE / 2)
          drain_rows();
        send_block(random_block(format_model), 1'b0, 32'h0);
      end
    end

    drain_rows();
    repeat (8) @(posedge clk);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
